// ===== rtl/core/lscsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lscsd_pkg
// Shared types and constants for the line sensor centroid / station detector.
// ----------------------------------------------------------------------------
package lscsd_pkg;

   localparam int NUM_SENSORS  = 11;
   localparam int QUEUE_DEPTH  = 2;

   localparam int SAMPLE_W     = 8;
   localparam int POS_W        = 8;
   localparam int STATION_W    = 2;
   localparam int WIDTH_W      = 4;
   localparam int COUNT_W      = 11;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 11;

   // weight of sensor i is WEIGHT_BASE + WEIGHT_STEP * i
   localparam int WEIGHT_BASE  = 11;
   localparam int WEIGHT_STEP  = 23;

   // side groups: left is sensors 0..4 (4 or more on tape), right is the last 4 (all)
   localparam int LEFT_GROUP_SIZE  = 5;
   localparam int LEFT_GROUP_MIN   = 4;
   localparam int RIGHT_GROUP_SIZE = 4;

   localparam logic [POS_W-1:0]    CENTRE_DEFAULT  = 8'd127;
   localparam logic [SAMPLE_W-1:0] TAPE_REF_RESET  = 8'd150;
   localparam logic [COUNT_W-1:0]  HOLD_RESET      = 11'd1500;
   localparam logic [COUNT_W-1:0]  RELEASE_RESET   = 11'd1450;

   typedef enum logic [1:0] {
      SIDE_LEFT    = 2'd0,
      SIDE_NONE    = 2'd1,
      SIDE_RIGHT   = 2'd2,
      SIDE_NO_TAPE = 2'd3
   } side_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TAPE_REF = 2'd0,
      CSR_HOLD     = 2'd1,
      CSR_RELEASE  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EVAL,
      BK_DIV,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      op_type                op;
      logic [SAMPLE_W-1:0]   sample;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] tape_ref;
      logic [COUNT_W-1:0]  hold_count;
      logic [COUNT_W-1:0]  release_count;
   } cfg_type;

endpackage

// ===== rtl/core/lscsd_front.sv =====
// ----------------------------------------------------------------------------
// lscsd_front
// Accepts request transactions, decodes the command and queues them.
// ----------------------------------------------------------------------------
module lscsd_front #(
   parameter int QUEUE_DEPTH = lscsd_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [lscsd_pkg::SAMPLE_W-1:0]  req_sample,
   output lscsd_pkg::queue_type            queue_out,
   input  logic                            queue_pop
);
   import lscsd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   item_type           push_item;

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      push_item.op     = req_command ? OP_CLEAR : OP_SAMPLE;
      push_item.sample = req_sample;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (queue_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !queue_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && queue_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_comb begin
      queue_out.valid = (count_ff != '0);
      queue_out.item  = entry_ff[rd_ptr_ff];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

// ===== rtl/core/lscsd_div.sv =====
// ----------------------------------------------------------------------------
// lscsd_div
// Restoring divider, one quotient bit per cycle. Quotient must fit QUOT_W.
// ----------------------------------------------------------------------------
module lscsd_div #(
   parameter int NUM_W  = 19,
   parameter int DEN_W  = 12,
   parameter int QUOT_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  numer,
   input  logic [DEN_W-1:0]  denom,
   output logic              busy,
   output logic              done,
   output logic [QUOT_W-1:0] quot
);
   import lscsd_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [DEN_W-1:0]  rem_ff,  rem_in;
   logic [DEN_W-1:0]  den_ff,  den_in;
   logic [QUOT_W-1:0] lo_ff,   lo_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;

   assign busy = (cnt_ff != '0);
   assign done = done_ff;
   assign quot = quot_ff;

   always_comb begin
      trial   = {rem_ff, lo_ff[QUOT_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      den_in  = den_ff;
      lo_in   = lo_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = (cnt_ff == CNT_W'(1));
      if (start) begin
         // top bits of the numerator are already below the divisor
         rem_in = DEN_W'(numer >> QUOT_W);
         lo_in  = numer[QUOT_W-1:0];
         den_in = denom;
         cnt_in = CNT_W'(QUOT_W);
      end else if (busy) begin
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         lo_in   = lo_ff << 1;
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      lo_ff   <= lo_in;
      quot_ff <= quot_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy && !done_ff)
      else $error("divider started while busy");

endmodule

// ===== rtl/core/lscsd_back.sv =====
// ----------------------------------------------------------------------------
// lscsd_back
// Executes queued transactions: sensor store, centroid scan, station detector
// and the response register.
// ----------------------------------------------------------------------------
module lscsd_back #(
   parameter int NUM_SENSORS = lscsd_pkg::NUM_SENSORS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lscsd_pkg::cfg_type               cfg,
   input  lscsd_pkg::queue_type             queue_in,
   output logic                             queue_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lscsd_pkg::POS_W-1:0]      rsp_line_position,
   output logic [lscsd_pkg::STATION_W-1:0]  rsp_station,
   output logic [lscsd_pkg::WIDTH_W-1:0]    rsp_tape_width
);
   import lscsd_pkg::*;

   localparam int IDX_W       = $clog2(NUM_SENSORS);
   localparam int MAX_SAMPLE  = (1 << SAMPLE_W) - 1;
   localparam int MAX_WEIGHT  = WEIGHT_BASE + WEIGHT_STEP * (NUM_SENSORS - 1);
   localparam int WT_W        = $clog2(MAX_WEIGHT + 1);
   localparam int SUM_WEIGHT  = WEIGHT_BASE * NUM_SENSORS
                              + WEIGHT_STEP * NUM_SENSORS * (NUM_SENSORS - 1) / 2;
   localparam int NUM_W       = $clog2(MAX_SAMPLE * SUM_WEIGHT + 1);
   localparam int DEN_W       = $clog2(MAX_SAMPLE * NUM_SENSORS + 1);
   localparam int PROD_W      = SAMPLE_W + WT_W;
   localparam int LG_W        = $clog2(LEFT_GROUP_SIZE + 1);
   localparam int RG_W        = $clog2(RIGHT_GROUP_SIZE + 1);
   localparam int RIGHT_FIRST = NUM_SENSORS - RIGHT_GROUP_SIZE;

   back_state_type       state_ff, state_in;
   logic [SAMPLE_W-1:0]  store_ff [NUM_SENSORS];
   logic [IDX_W-1:0]     chan_ff,   chan_in;
   logic [IDX_W-1:0]     scan_ff,   scan_in;
   logic [WT_W-1:0]      weight_ff, weight_in;
   logic [NUM_W-1:0]     num_ff,    num_in;
   logic [DEN_W-1:0]     den_ff,    den_in;
   logic [WIDTH_W-1:0]   tcnt_ff,   tcnt_in;
   logic [LG_W-1:0]      lcnt_ff,   lcnt_in;
   logic [RG_W-1:0]      rcnt_ff,   rcnt_in;
   op_type               op_ff,     op_in;
   logic [POS_W-1:0]     centre_ff, centre_in;
   side_type             cand_ff,   cand_in;
   logic [COUNT_W-1:0]   cnt_ff,    cnt_in;
   side_type             conf_ff,   conf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic [STATION_W-1:0] rsp_station_ff;
   logic [WIDTH_W-1:0]   rsp_width_ff;

   logic                 store_we;
   logic                 out_load;
   logic [SAMPLE_W-1:0]  rd_sample;
   logic [PROD_W-1:0]    product;
   logic                 on_tape;
   logic                 left_on;
   logic                 right_on;
   side_type             det_cand;
   logic [COUNT_W-1:0]   det_cnt;
   side_type             det_conf;
   logic [POS_W-1:0]     out_pos;
   side_type             out_station;

   logic                 div_start;
   logic                 div_busy;
   logic                 div_done;
   logic [POS_W-1:0]     div_quot;

   lscsd_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (DEN_W),
      .QUOT_W (POS_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (num_ff),
      .denom (den_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   // scan datapath: one sensor per cycle
   always_comb begin
      rd_sample = store_ff[scan_ff];
      product   = PROD_W'(rd_sample) * PROD_W'(weight_ff);
      on_tape   = (rd_sample >= cfg.tape_ref);
      left_on   = (lcnt_ff >= LG_W'(LEFT_GROUP_MIN));
      right_on  = (rcnt_ff == RG_W'(RIGHT_GROUP_SIZE));
   end

   // station detector step, first matching rule wins
   always_comb begin
      det_cand = cand_ff;
      det_cnt  = cnt_ff;
      det_conf = conf_ff;
      priority if (cand_ff == SIDE_LEFT && right_on) begin
         det_cand = SIDE_NONE;
      end else if (cand_ff == SIDE_RIGHT && left_on) begin
         det_cand = SIDE_NONE;
      end else if (cand_ff == SIDE_LEFT && !left_on && cnt_ff > cfg.release_count) begin
         det_cand = SIDE_NONE;
         det_cnt  = '0;
      end else if (cand_ff == SIDE_RIGHT && !right_on && cnt_ff > cfg.release_count) begin
         det_cand = SIDE_NONE;
         det_cnt  = '0;
      end else if (cnt_ff != '0) begin
         det_cnt = cnt_ff - 1'b1;
      end else if (cand_ff == SIDE_NONE) begin
         if (right_on) begin
            det_cand = SIDE_RIGHT;
            det_cnt  = cfg.hold_count;
         end else if (left_on) begin
            det_cand = SIDE_LEFT;
            det_cnt  = cfg.hold_count;
         end
      end else if (cand_ff == SIDE_LEFT) begin
         det_conf = SIDE_LEFT;
      end else if (cand_ff == SIDE_RIGHT) begin
         det_conf = SIDE_RIGHT;
      end
   end

   // response fields from the settled state
   always_comb begin
      out_pos     = centre_ff;
      out_station = SIDE_NONE;
      if (conf_ff == SIDE_LEFT || conf_ff == SIDE_RIGHT) begin
         out_station = conf_ff;
      end else if (tcnt_ff == '0) begin
         out_station = SIDE_NO_TAPE;
         out_pos     = CENTRE_DEFAULT;
      end
   end

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      scan_in      = scan_ff;
      weight_in    = weight_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      tcnt_in      = tcnt_ff;
      lcnt_in      = lcnt_ff;
      rcnt_in      = rcnt_ff;
      op_in        = op_ff;
      centre_in    = centre_ff;
      cand_in      = cand_ff;
      cnt_in       = cnt_ff;
      conf_in      = conf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      queue_pop    = 1'b0;
      store_we     = 1'b0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (queue_in.valid) begin
               queue_pop = 1'b1;
               op_in     = queue_in.item.op;
               scan_in   = '0;
               weight_in = WT_W'(WEIGHT_BASE);
               num_in    = '0;
               den_in    = '0;
               tcnt_in   = '0;
               lcnt_in   = '0;
               rcnt_in   = '0;
               state_in  = BK_SCAN;
               if (queue_in.item.op == OP_SAMPLE) begin
                  store_we = 1'b1;
                  chan_in  = (chan_ff == IDX_W'(NUM_SENSORS - 1)) ? '0 : chan_ff + 1'b1;
               end else begin
                  cand_in = SIDE_NONE;
                  cnt_in  = '0;
                  conf_in = SIDE_NONE;
               end
            end
         end
         BK_SCAN: begin
            num_in    = num_ff + NUM_W'(product);
            den_in    = den_ff + DEN_W'(rd_sample);
            weight_in = weight_ff + WT_W'(WEIGHT_STEP);
            if (on_tape) begin
               tcnt_in = tcnt_ff + 1'b1;
               if (scan_ff < IDX_W'(LEFT_GROUP_SIZE)) begin
                  lcnt_in = lcnt_ff + 1'b1;
               end
               if (scan_ff >= IDX_W'(RIGHT_FIRST)) begin
                  rcnt_in = rcnt_ff + 1'b1;
               end
            end
            if (scan_ff == IDX_W'(NUM_SENSORS - 1)) begin
               state_in = BK_EVAL;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         BK_EVAL: begin
            if (op_ff == OP_CLEAR) begin
               state_in = BK_OUT;
            end else if (left_on || right_on || den_ff == '0) begin
               centre_in = CENTRE_DEFAULT;
               cand_in   = det_cand;
               cnt_in    = det_cnt;
               conf_in   = det_conf;
               state_in  = BK_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = BK_DIV;
            end
         end
         BK_DIV: begin
            if (div_done) begin
               centre_in = div_quot;
               cand_in   = det_cand;
               cnt_in    = det_cnt;
               conf_in   = det_conf;
               state_in  = BK_OUT;
            end
         end
         BK_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         chan_ff      <= '0;
         centre_ff    <= CENTRE_DEFAULT;
         cand_ff      <= SIDE_NONE;
         cnt_ff       <= '0;
         conf_ff      <= SIDE_NONE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SENSORS; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         centre_ff    <= centre_in;
         cand_ff      <= cand_in;
         cnt_ff       <= cnt_in;
         conf_ff      <= conf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (store_we) begin
            store_ff[chan_ff] <= queue_in.item.sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      weight_ff <= weight_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      tcnt_ff   <= tcnt_in;
      lcnt_ff   <= lcnt_in;
      rcnt_ff   <= rcnt_in;
      op_ff     <= op_in;
      if (out_load) begin
         rsp_pos_ff     <= out_pos;
         rsp_station_ff <= out_station;
         rsp_width_ff   <= tcnt_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_position = rsp_pos_ff;
   assign rsp_station       = rsp_station_ff;
   assign rsp_tape_width    = rsp_width_ff;

   a_no_tape_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_station == SIDE_NO_TAPE |->
         rsp_line_position == CENTRE_DEFAULT && rsp_tape_width == '0)
      else $error("no-tape result with position or width set");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == BK_DIV)
      else $error("divider finished outside divide state");

   a_div_busy_state: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == BK_DIV)
      else $error("divider running outside divide state");

endmodule

// ===== rtl/core/line_sensor_centroid_station_detect.sv =====
// ----------------------------------------------------------------------------
// line_sensor_centroid_station_detect
// Line sensor centroid with left/right station detection.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per sensor reading (req_command = 0) or a
//            station clear (req_command = 1). Accepted when req_valid is high
//            and req_stall is low. A two-entry queue sits in front of the
//            execution unit, so req_stall only rises when that queue is full.
//   rsp_*  : exactly one response transaction per request, in order, held in
//            an output register. While rsp_stall is high the response holds
//            and the execution unit waits in its output state; the queue
//            keeps taking requests until full.
//   csr_*  : register writes (0 tape reference, 1 hold count, 2 release
//            count); csr_ready is always high. Write only while idle.
// Timing: each transaction scans all NUM_SENSORS slots, one per cycle; a
//   sample then runs an 8-step restoring divide for the centroid, while a
//   clear, or a sample with side tape or zero sum, goes straight to the
//   output state. The execution unit takes a new queued transaction only
//   once the previous response is loaded; the queue accepts meanwhile.
// Reset (synchronous, active high): sensor slots zero, channel 0, centre 127,
//   detector idle, registers at 150 / 1500 / 1450, queue and response empty.
// ----------------------------------------------------------------------------
module line_sensor_centroid_station_detect #(
   parameter int NUM_SENSORS = lscsd_pkg::NUM_SENSORS,
   parameter int QUEUE_DEPTH = lscsd_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [lscsd_pkg::SAMPLE_W-1:0]     req_sample,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lscsd_pkg::POS_W-1:0]        rsp_line_position,
   output logic [lscsd_pkg::STATION_W-1:0]    rsp_station,
   output logic [lscsd_pkg::WIDTH_W-1:0]      rsp_tape_width,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lscsd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lscsd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lscsd_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   queue_type queue;
   logic      queue_pop;
   logic      csr_write;

   // register file: always ready, writes outside the map are dropped
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TAPE_REF: cfg_in.tape_ref      = csr_wdata[SAMPLE_W-1:0];
            CSR_HOLD:     cfg_in.hold_count    = csr_wdata[COUNT_W-1:0];
            CSR_RELEASE:  cfg_in.release_count = csr_wdata[COUNT_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tape_ref      <= TAPE_REF_RESET;
         cfg_ff.hold_count    <= HOLD_RESET;
         cfg_ff.release_count <= RELEASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, decode command, queue
   lscsd_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_sample  (req_sample),
      .queue_out   (queue),
      .queue_pop   (queue_pop)
   );

   // back: store, scan, divide, detector, response register
   lscsd_back #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .queue_in          (queue),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_line_position (rsp_line_position),
      .rsp_station       (rsp_station),
      .rsp_tape_width    (rsp_tape_width)
   );

endmodule
